[src/cifa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cifa_pkg
// Shared types and constants for the checked integer fold ALU.
// ----------------------------------------------------------------------------
package cifa_pkg;

  localparam int DataWidthDef = 64;

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_MOD = 3'd4,
    CMD_POW = 3'd5,
    CMD_MIN = 3'd6,
    CMD_MAX = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_OVF    = 2'd1,
    ST_DIV0   = 2'd2,
    ST_NEGEXP = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_RUN,
    S_COMMIT,
    S_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic step;
    logic commit;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic go_unit;
    logic unit_done;
    logic pow_more;
    logic last;
  } dp_stat_t;

endpackage

[src/cifa_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cifa_datapath
// Sign-magnitude accumulator, combinational add/sub/min/max and a shared
// bit-serial multiply/divide unit that also drives the power loop.
// ----------------------------------------------------------------------------
module cifa_datapath import cifa_pkg::*; #(
  parameter int DW = DataWidthDef
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ctrl_cmd_t            cmd,
  output dp_stat_t             stat,
  input  logic [2:0]           in_command,
  input  logic signed [DW-1:0] in_operand,
  input  logic                 in_last,
  output logic signed [DW-1:0] out_value,
  output logic [1:0]           out_status
);

  localparam int CW = $clog2(DW);
  localparam logic [DW-1:0] LIMIT   = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW:0]   LIMIT_X = {2'b00, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] EXP_MAX = DW'(DW - 1);
  localparam logic [CW-1:0] CNT_TOP = CW'(DW - 1);
  localparam logic [CW-1:0] PE_ONE  = CW'(1);

  op_t            cmd_r, cmd_nxt;
  logic           xneg_r, xneg_nxt;
  logic [DW-1:0]  xmag_r, xmag_nxt;
  logic           last_r, last_nxt;
  logic           acc_neg_r, acc_neg_nxt;
  logic [DW-1:0]  acc_mag_r, acc_mag_nxt;
  status_t        err_r, err_nxt;
  logic           open_r, open_nxt;
  logic [DW-1:0]  mp_r, mp_nxt;
  logic [DW-1:0]  mq_r, mq_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [CW-1:0]  pe_r, pe_nxt;
  logic           movf_r, movf_nxt;
  logic [DW-1:0]  out_value_r, out_value_nxt;
  status_t        out_status_r, out_status_nxt;

  logic [DW-1:0]  op_u;
  logic           bad, active, go_mul, go_div, go_pow, div_mode;
  logic           bneg, same, lt, gt, seed_neg;
  logic [DW:0]    sum;
  logic [DW-1:0]  as_mag;
  logic           as_neg, as_ovf;
  logic [DW-1:0]  sh;
  logic [DW:0]    msum;

  assign op_u     = in_operand;
  assign bad      = xmag_r > LIMIT;
  assign active   = open_r && (err_r == ST_OK) && !bad;
  assign go_mul   = active && (cmd_r == CMD_MUL);
  assign go_div   = active && ((cmd_r == CMD_DIV) || (cmd_r == CMD_MOD)) && (xmag_r != '0);
  assign go_pow   = active && (cmd_r == CMD_POW) && !xneg_r && (xmag_r != '0)
                    && (acc_mag_r > DW'(1)) && (xmag_r <= EXP_MAX);
  assign div_mode = (cmd_r == CMD_DIV) || (cmd_r == CMD_MOD);

  assign stat.go_unit   = go_mul || go_div || go_pow;
  assign stat.unit_done = cnt_r == '0;
  assign stat.pow_more  = (cmd_r == CMD_POW) && !movf_r && (pe_r != PE_ONE);
  assign stat.last      = last_r;

  // add and subtract in sign-magnitude
  assign bneg = (cmd_r == CMD_SUB) ? (!xneg_r && (xmag_r != '0)) : xneg_r;
  assign same = acc_neg_r == bneg;
  assign sum  = {1'b0, acc_mag_r} + {1'b0, xmag_r};

  always_comb begin
    as_ovf = 1'b0;
    if (same) begin
      as_mag = sum[DW-1:0];
      as_neg = acc_neg_r;
      as_ovf = sum > LIMIT_X;
    end else if (acc_mag_r >= xmag_r) begin
      as_mag = acc_mag_r - xmag_r;
      as_neg = acc_neg_r;
    end else begin
      as_mag = xmag_r - acc_mag_r;
      as_neg = bneg;
    end
  end

  assign lt = (acc_neg_r && !xneg_r) || (!acc_neg_r && !xneg_r && (acc_mag_r < xmag_r))
              || (acc_neg_r && xneg_r && (acc_mag_r > xmag_r));
  assign gt = (!acc_neg_r && xneg_r) || (!acc_neg_r && !xneg_r && (acc_mag_r > xmag_r))
              || (acc_neg_r && xneg_r && (acc_mag_r < xmag_r));
  assign seed_neg = (last_r && (cmd_r == CMD_SUB)) ? (!xneg_r && (xmag_r != '0)) : xneg_r;

  // one step of the shared unit
  assign sh   = {mp_r[DW-2:0], mq_r[DW-1]};
  assign msum = {mp_r, 1'b0} + (mq_r[DW-1] ? {1'b0, acc_mag_r} : '0);

  always_comb begin
    cmd_nxt        = cmd_r;
    xneg_nxt       = xneg_r;
    xmag_nxt       = xmag_r;
    last_nxt       = last_r;
    acc_neg_nxt    = acc_neg_r;
    acc_mag_nxt    = acc_mag_r;
    err_nxt        = err_r;
    open_nxt       = open_r;
    mp_nxt         = mp_r;
    mq_nxt         = mq_r;
    cnt_nxt        = cnt_r;
    pe_nxt         = pe_r;
    movf_nxt       = movf_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;

    if (cmd.load) begin
      cmd_nxt  = op_t'(in_command);
      xneg_nxt = op_u[DW-1];
      xmag_nxt = op_u[DW-1] ? (~op_u + DW'(1)) : op_u;
      last_nxt = in_last;
    end

    if (cmd.eval) begin
      if (!open_r) begin
        open_nxt = 1'b1;
        if (bad) begin
          err_nxt     = ST_OVF;
          acc_neg_nxt = 1'b0;
          acc_mag_nxt = '0;
        end else begin
          err_nxt     = ST_OK;
          acc_neg_nxt = seed_neg;
          acc_mag_nxt = xmag_r;
        end
      end else if (err_r == ST_OK) begin
        if (bad) begin
          err_nxt = ST_OVF;
        end else if (go_mul || go_div || go_pow) begin
          mp_nxt   = '0;
          cnt_nxt  = CNT_TOP;
          movf_nxt = 1'b0;
          pe_nxt   = xmag_r[CW-1:0];
          if (go_mul) begin
            mq_nxt = xmag_r;
          end else if (go_div) begin
            mq_nxt = acc_mag_r;
          end else begin
            mq_nxt = DW'(1);
          end
        end else begin
          case (cmd_r)
            CMD_ADD, CMD_SUB: begin
              if (as_ovf) begin
                err_nxt = ST_OVF;
              end else begin
                acc_neg_nxt = as_neg && (as_mag != '0);
                acc_mag_nxt = as_mag;
              end
            end
            CMD_DIV, CMD_MOD: begin
              err_nxt = ST_DIV0;
            end
            CMD_POW: begin
              if (xneg_r) begin
                err_nxt = ST_NEGEXP;
              end else if (xmag_r == '0) begin
                acc_neg_nxt = 1'b0;
                acc_mag_nxt = DW'(1);
              end else if (acc_mag_r <= DW'(1)) begin
                acc_neg_nxt = acc_neg_r && xmag_r[0];
              end else begin
                err_nxt = ST_OVF;
              end
            end
            CMD_MIN: begin
              if (!lt) begin
                acc_neg_nxt = xneg_r;
                acc_mag_nxt = xmag_r;
              end
            end
            CMD_MAX: begin
              if (!gt) begin
                acc_neg_nxt = xneg_r;
                acc_mag_nxt = xmag_r;
              end
            end
            default: begin
              err_nxt = err_r;
            end
          endcase
        end
      end
    end

    if (cmd.step) begin
      cnt_nxt = cnt_r - CW'(1);
      if (div_mode) begin
        if (sh >= xmag_r) begin
          mp_nxt = sh - xmag_r;
          mq_nxt = {mq_r[DW-2:0], 1'b1};
        end else begin
          mp_nxt = sh;
          mq_nxt = {mq_r[DW-2:0], 1'b0};
        end
      end else begin
        mq_nxt = {mq_r[DW-2:0], 1'b0};
        if (!movf_r) begin
          if (msum > LIMIT_X) begin
            movf_nxt = 1'b1;
          end else begin
            mp_nxt = msum[DW-1:0];
          end
        end
      end
    end

    if (cmd.commit) begin
      case (cmd_r)
        CMD_MUL: begin
          if (movf_r) begin
            err_nxt = ST_OVF;
          end else begin
            acc_neg_nxt = (acc_neg_r ^ xneg_r) && (mp_r != '0);
            acc_mag_nxt = mp_r;
          end
        end
        CMD_DIV: begin
          acc_neg_nxt = (acc_neg_r ^ xneg_r) && (mq_r != '0);
          acc_mag_nxt = mq_r;
        end
        CMD_MOD: begin
          acc_neg_nxt = acc_neg_r && (mp_r != '0);
          acc_mag_nxt = mp_r;
        end
        CMD_POW: begin
          if (movf_r) begin
            err_nxt = ST_OVF;
          end else if (pe_r == PE_ONE) begin
            acc_neg_nxt = acc_neg_r && xmag_r[0];
            acc_mag_nxt = mp_r;
          end else begin
            pe_nxt   = pe_r - CW'(1);
            mp_nxt   = '0;
            mq_nxt   = mp_r;
            cnt_nxt  = CNT_TOP;
            movf_nxt = 1'b0;
          end
        end
        default: begin
          err_nxt = err_r;
        end
      endcase
    end

    if (cmd.emit) begin
      out_status_nxt = err_r;
      if (err_r == ST_OK) begin
        out_value_nxt = acc_neg_r ? (~acc_mag_r + DW'(1)) : acc_mag_r;
      end else begin
        out_value_nxt = '0;
      end
      open_nxt    = 1'b0;
      err_nxt     = ST_OK;
      acc_neg_nxt = 1'b0;
      acc_mag_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_neg_r <= 1'b0;
      acc_mag_r <= '0;
      err_r     <= ST_OK;
      open_r    <= 1'b0;
      cnt_r     <= '0;
    end else begin
      acc_neg_r <= acc_neg_nxt;
      acc_mag_r <= acc_mag_nxt;
      err_r     <= err_nxt;
      open_r    <= open_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    xneg_r       <= xneg_nxt;
    xmag_r       <= xmag_nxt;
    last_r       <= last_nxt;
    mp_r         <= mp_nxt;
    mq_r         <= mq_nxt;
    pe_r         <= pe_nxt;
    movf_r       <= movf_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_value  = out_value_r;
  assign out_status = out_status_r;

endmodule

[src/cifa_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cifa_ctrl
// Sequencer: takes a request, evaluates it, runs the shared unit if needed and
// delivers the run's result through the output register.
// ----------------------------------------------------------------------------
module cifa_ctrl import cifa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   can_emit;

  assign can_emit = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        state_nxt = stat.go_unit ? S_RUN : S_FIN;
      end
      S_RUN: begin
        if (stat.unit_done) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        state_nxt = stat.pow_more ? S_RUN : S_FIN;
      end
      S_FIN: begin
        if (!stat.last || can_emit) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
      end
      S_RUN: begin
        cmd.step = 1'b1;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
      end
      S_FIN: begin
        cmd.emit = stat.last && can_emit;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[src/checked_integer_fold_alu_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// checked_integer_fold_alu_core
// Folds a run of signed operands under add, sub, mul, div, mod, pow, min or
// max with overflow, divide-by-zero and negative-exponent checking.
// ----------------------------------------------------------------------------
// One operand is taken at a time. Add, sub, min, max, seeds and operands
// after an error skip the shared unit; mul, div and mod run on the
// bit-serial multiply/divide unit; pow runs that same unit once per
// exponent step. The run's result is loaded into the output register when
// the operand marked last finishes and the output register is free or
// being taken.
module checked_integer_fold_alu_core import cifa_pkg::*; #(
  parameter int DATA_WIDTH = DataWidthDef
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [2:0]                   in_command,
  input  logic signed [DATA_WIDTH-1:0] in_operand,
  input  logic                         in_last,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] out_value,
  output logic [1:0]                   out_status
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  cifa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cifa_datapath #(
    .DW (DATA_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_command (in_command),
    .in_operand (in_operand),
    .in_last    (in_last),
    .out_value  (out_value),
    .out_status (out_status)
  );

endmodule

[tb/checked_integer_fold_alu_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// checked_integer_fold_alu_core_tb
// Drives runs of operands into the fold ALU under every command and checks
// each folded result against a sign-magnitude predictor that tracks overflow,
// divide-by-zero and negative-exponent errors. Directed runs cover the edges,
// then random runs follow, with bursty requests and random output stalls.
// ----------------------------------------------------------------------------
module checked_integer_fold_alu_core_tb;
  import cifa_pkg::*;

  localparam logic [63:0] MAG_LIMIT = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] MOST_NEG = 64'h8000_0000_0000_0000;
  localparam int IDLE_LIMIT = 40000;
  localparam int RANDOM_ITEMS = 1880;

  typedef struct packed {
    logic        neg;
    logic [63:0] mag;
  } smag_t;

  typedef struct packed {
    op_t         cmd;
    logic [63:0] operand;
    logic        last;
    logic        hold;
  } request_t;

  typedef struct packed {
    logic [63:0] value;
    status_t     status;
  } fold_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_command;
  logic signed [63:0] in_operand;
  logic        in_last;
  logic        out_valid;
  logic        out_ready;
  logic signed [63:0] out_value;
  logic [1:0]  out_status;

  request_t     pending_q[$];
  fold_result_t folded_q[$];

  logic signed [63:0] acc_q;
  status_t     err_q;
  logic        open_q;

  logic        req_taken;
  int          burst_left;
  int          gap_left;
  int          hold_left;
  logic        hold_done;
  int          stall_phase;
  int          idle_cycles;
  int          mismatches;
  int          requests_in;
  int          results_out;
  int          error_results;
  int          op_seen[8];

  checked_integer_fold_alu_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_command(in_command),
    .in_operand(in_operand), .in_last(in_last),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_value(out_value), .out_status(out_status)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic smag_t sm_make(logic n, logic [63:0] m);
    smag_t r;
    r.mag = m;
    r.neg = n && (m != 64'd0);
    return r;
  endfunction

  function automatic smag_t sm_of(logic [63:0] raw);
    if (raw[63]) return sm_make(1'b1, ~raw + 64'd1);
    return sm_make(1'b0, raw);
  endfunction

  function automatic logic signed [63:0] sm_value(smag_t a);
    return a.neg ? -$signed(a.mag) : $signed(a.mag);
  endfunction

  function automatic status_t sm_add(smag_t a, smag_t b, output smag_t r);
    logic [63:0] m;
    if (a.neg == b.neg) begin
      m = a.mag + b.mag;
      if (m > MAG_LIMIT) return ST_OVF;
      r = sm_make(a.neg, m);
    end else if (a.mag >= b.mag) begin
      r = sm_make(a.neg, a.mag - b.mag);
    end else begin
      r = sm_make(b.neg, b.mag - a.mag);
    end
    return ST_OK;
  endfunction

  function automatic status_t combine(op_t c, smag_t a, smag_t b, output smag_t r);
    logic [63:0] p;
    logic [63:0] k;
    r = sm_make(1'b0, 64'd0);
    case (c)
      CMD_ADD: return sm_add(a, b, r);
      CMD_SUB: return sm_add(a, sm_make(!b.neg, b.mag), r);
      CMD_MUL: begin
        if (b.mag != 0 && a.mag > MAG_LIMIT / b.mag) return ST_OVF;
        r = sm_make(a.neg != b.neg, a.mag * b.mag);
      end
      CMD_DIV: begin
        if (b.mag == 0) return ST_DIV0;
        r = sm_make(a.neg != b.neg, a.mag / b.mag);
      end
      CMD_MOD: begin
        if (b.mag == 0) return ST_DIV0;
        r = sm_make(a.neg, a.mag % b.mag);
      end
      CMD_POW: begin
        if (b.neg) return ST_NEGEXP;
        if (b.mag == 0) begin
          r = sm_make(1'b0, 64'd1);
        end else if (a.mag <= 1) begin
          r = sm_make(a.neg && b.mag[0], a.mag);
        end else begin
          p = 64'd1;
          for (k = 0; k < b.mag; k++) begin
            if (p > MAG_LIMIT / a.mag) return ST_OVF;
            p = p * a.mag;
          end
          r = sm_make(a.neg && b.mag[0], p);
        end
      end
      CMD_MIN: r = (sm_value(a) < sm_value(b)) ? a : b;
      default: r = (sm_value(a) > sm_value(b)) ? a : b;
    endcase
    return ST_OK;
  endfunction

  task automatic fold_accept(op_t c, logic [63:0] raw, logic last);
    smag_t x;
    smag_t r;
    status_t st;
    fold_result_t res;
    x = sm_of(raw);
    if (!open_q) begin
      open_q = 1'b1;
      acc_q = 64'sd0;
      err_q = ST_OK;
      if (x.mag > MAG_LIMIT) begin
        err_q = ST_OVF;
      end else begin
        if (last && c == CMD_SUB) x = sm_make(!x.neg, x.mag);
        acc_q = sm_value(x);
      end
    end else if (err_q == ST_OK) begin
      if (x.mag > MAG_LIMIT) begin
        err_q = ST_OVF;
      end else begin
        st = combine(c, sm_of(acc_q), x, r);
        err_q = st;
        if (st == ST_OK) acc_q = sm_value(r);
      end
    end
    if (last) begin
      res.value = (err_q == ST_OK) ? acc_q : 64'd0;
      res.status = err_q;
      folded_q.push_back(res);
      open_q = 1'b0;
      acc_q = 64'sd0;
      err_q = ST_OK;
    end
  endtask

  function automatic logic [63:0] rand_operand();
    case ($urandom_range(0, 9))
      0: return {$urandom, $urandom};
      1: begin
        case ($urandom_range(0, 5))
          0: return MAG_LIMIT;
          1: return -MAG_LIMIT;
          2: return MOST_NEG;
          3: return 64'd0;
          4: return 64'd1;
          default: return -64'sd1;
        endcase
      end
      2, 3: return $signed({{32{1'b0}}, $urandom}) - 64'sd2147483648;
      4: return {{32{$urandom_range(0, 1) ? 1'b1 : 1'b0}}, $urandom};
      default: return $signed(64'($urandom_range(0, 40))) - 64'sd20;
    endcase
  endfunction

  task automatic queue_req(op_t c, logic [63:0] v, logic last, logic hold = 1'b0);
    request_t t;
    t.cmd = c;
    t.operand = v;
    t.last = last;
    t.hold = hold;
    pending_q.push_back(t);
  endtask

  task automatic queue_random_run(logic hold);
    op_t c;
    int n;
    logic [63:0] v;
    c = op_t'($urandom_range(0, 7));
    n = $urandom_range(1, 5);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 15) == 0) c = op_t'($urandom_range(0, 7));
      v = rand_operand();
      if (c == CMD_POW && i > 0) begin
        case ($urandom_range(0, 7))
          0: v = -64'($urandom_range(1, 5));
          1: v = 64'($urandom_range(0, 70));
          2: v = {$urandom, $urandom};
          default: v = 64'($urandom_range(0, 6));
        endcase
      end else if (c == CMD_POW && $urandom_range(0, 2) != 0) begin
        v = $signed(64'($urandom_range(0, 16))) - 64'sd8;
      end
      if ((c == CMD_DIV || c == CMD_MOD) && $urandom_range(0, 9) == 0) v = 64'd0;
      queue_req(c, v, i == n - 1, hold && i == 0);
    end
  endtask

  // predictor update and result checking
  always @(posedge clk) begin
    fold_result_t want;
    req_taken <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        requests_in++;
        op_seen[in_command]++;
        fold_accept(op_t'(in_command), in_operand, in_last);
      end
      if (out_valid && out_ready) begin
        results_out++;
        if (folded_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result value=%0d status=%0d", out_value, out_status);
        end else begin
          want = folded_q.pop_front();
          if (want.status != ST_OK) error_results++;
          if (out_value !== want.value || out_status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: expected value=%0d status=%0d, got value=%0d status=%0d",
                       results_out, $signed(want.value), want.status, out_value,
                       out_status);
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no handshake in %0d cycles", IDLE_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // request driver
  always @(negedge clk) begin
    request_t t;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !req_taken) begin
      in_valid <= 1'b1;
    end else if (gap_left > 0) begin
      gap_left--;
      in_valid <= 1'b0;
    end else if (pending_q.size() == 0 ||
                 (pending_q[0].hold && (folded_q.size() != 0 || in_valid))) begin
      in_valid <= 1'b0;
    end else begin
      t = pending_q.pop_front();
      in_command <= t.cmd;
      in_operand <= t.operand;
      in_last <= t.last;
      in_valid <= 1'b1;
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 24);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      end
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && requests_in >= 700) begin
      hold_done = 1'b1;
      hold_left = 600;
      out_ready <= 1'b0;
    end else begin
      stall_phase = (stall_phase + 1) % 256;
      if (stall_phase < 64) out_ready <= 1'b1;
      else if (stall_phase < 160) out_ready <= ($urandom_range(0, 3) != 0);
      else out_ready <= ($urandom_range(0, 1) != 0);
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = '0;
    in_operand = '0;
    in_last = 1'b0;
    out_ready = 1'b0;
    req_taken = 1'b0;
    acc_q = '0;
    err_q = ST_OK;
    open_q = 1'b0;
    burst_left = 4;
    gap_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    stall_phase = 0;
    idle_cycles = 0;
    mismatches = 0;
    requests_in = 0;
    results_out = 0;
    error_results = 0;
    foreach (op_seen[i]) op_seen[i] = 0;

    // edges and error cases
    queue_req(CMD_ADD, MAG_LIMIT, 1'b0);
    queue_req(CMD_ADD, 64'd1, 1'b1);
    queue_req(CMD_SUB, -MAG_LIMIT, 1'b1);
    queue_req(CMD_ADD, MOST_NEG, 1'b1);
    queue_req(CMD_SUB, 64'd5, 1'b0);
    queue_req(CMD_SUB, 64'd9, 1'b1);
    queue_req(CMD_MUL, 64'h1_0000_0000, 1'b0);
    queue_req(CMD_MUL, 64'h8000_0000, 1'b1);
    queue_req(CMD_DIV, -64'sd7, 1'b0);
    queue_req(CMD_DIV, 64'd2, 1'b1);
    queue_req(CMD_MOD, -64'sd7, 1'b0);
    queue_req(CMD_MOD, 64'd0, 1'b0);
    queue_req(CMD_ADD, MOST_NEG, 1'b1);
    queue_req(CMD_POW, 64'd0, 1'b0);
    queue_req(CMD_POW, 64'd0, 1'b1);
    queue_req(CMD_POW, -64'sd3, 1'b0);
    queue_req(CMD_POW, -64'sd1, 1'b1);
    queue_req(CMD_POW, 64'd2, 1'b0);
    queue_req(CMD_POW, 64'd63, 1'b1);
    queue_req(CMD_MIN, -MAG_LIMIT, 1'b0);
    queue_req(CMD_MAX, MAG_LIMIT, 1'b1);
    queue_req(CMD_MAX, 64'd3, 1'b0);
    queue_req(CMD_MIN, MOST_NEG, 1'b1);

    while (pending_q.size() < RANDOM_ITEMS + 23)
      queue_random_run(pending_q.size() > 1200 && pending_q.size() < 1206);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (pending_q.size() != 0 || in_valid || folded_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("covered %0d requests and %0d folded results, %0d ending in an error",
             requests_in, results_out, error_results);
    $display("requests per command add..max: %0d %0d %0d %0d %0d %0d %0d %0d",
             op_seen[0], op_seen[1], op_seen[2], op_seen[3], op_seen[4], op_seen[5],
             op_seen[6], op_seen[7]);
    if (mismatches == 0 && folded_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[sim.f]
src/cifa_pkg.sv
src/cifa_datapath.sv
src/cifa_ctrl.sv
src/checked_integer_fold_alu_core.sv
tb/checked_integer_fold_alu_core_tb.sv
